/* hdl/bnc_pkg.sv */
// bnc_pkg: shared types, codes and decode functions for the bracket nesting checker
// depends on: nothing

package bnc_pkg;

    // default number of stack cells
    localparam int STACK_DEPTH_DEF = 64;

    localparam int CODE_W   = 2;
    localparam int POINTS_W = 15;
    localparam int TOTAL_W  = 64;
    localparam int SCORE_W  = 64;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // bracket characters
    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    // bracket kind codes held in the stack
    localparam logic [CODE_W-1:0] KIND_PAREN  = 2'd0;
    localparam logic [CODE_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [CODE_W-1:0] KIND_CURLY  = 2'd2;
    localparam logic [CODE_W-1:0] KIND_ANGLE  = 2'd3;

    // closer points
    localparam logic [POINTS_W-1:0] PTS_PAREN  = 15'd3;
    localparam logic [POINTS_W-1:0] PTS_SQUARE = 15'd57;
    localparam logic [POINTS_W-1:0] PTS_CURLY  = 15'd1197;
    localparam logic [POINTS_W-1:0] PTS_ANGLE  = 15'd25137;
    localparam logic [POINTS_W-1:0] PTS_NONE   = 15'd0;

    // line status codes
    localparam logic [STATUS_W-1:0] STATUS_CLEAN    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CORRUPT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] kind;
    } bracket_t;

    function automatic bracket_t opener_decode(input logic [7:0] c);
        bracket_t r;
        r.hit = 1'b1;
        case (c)
            CH_OPEN_PAREN:  r.kind = KIND_PAREN;
            CH_OPEN_SQUARE: r.kind = KIND_SQUARE;
            CH_OPEN_CURLY:  r.kind = KIND_CURLY;
            CH_OPEN_ANGLE:  r.kind = KIND_ANGLE;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = KIND_PAREN;
            end
        endcase
        return r;
    endfunction

    function automatic bracket_t closer_decode(input logic [7:0] c);
        bracket_t r;
        r.hit = 1'b1;
        case (c)
            CH_CLOSE_PAREN:  r.kind = KIND_PAREN;
            CH_CLOSE_SQUARE: r.kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  r.kind = KIND_CURLY;
            CH_CLOSE_ANGLE:  r.kind = KIND_ANGLE;
            default:
            begin
                r.hit  = 1'b0;
                r.kind = KIND_PAREN;
            end
        endcase
        return r;
    endfunction

    function automatic logic [POINTS_W-1:0] closer_points(input logic [7:0] c);
        logic [POINTS_W-1:0] p;
        case (c)
            CH_CLOSE_PAREN:  p = PTS_PAREN;
            CH_CLOSE_SQUARE: p = PTS_SQUARE;
            CH_CLOSE_CURLY:  p = PTS_CURLY;
            CH_CLOSE_ANGLE:  p = PTS_ANGLE;
            default:         p = PTS_NONE;
        endcase
        return p;
    endfunction

endpackage

/* hdl/bracket_nesting_checker.sv */
// bracket_nesting_checker: top level of the balanced bracket checker
// depends on: bnc_pkg, bnc_stack (bnc_cell)

// Takes one byte of a line per word on the input channel; openers '(' '[' '{' '<' are
// pushed onto a chain of STACK_DEPTH shift cells and every other byte pops and must match.
// Ordinary bytes go at one per cycle. After a byte with last set, the input stalls while
// the completion score is formed by popping the cell chain one base-5 digit per cycle
// (no digits for a corrupted or overflowed line), and while the output register waits for
// out_ready. One result word is given per line. The stack needs no clearing pass; a held
// count marks its live cells.

module bracket_nesting_checker #(
    parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   ch,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bnc_pkg::STATUS_W-1:0] line_status,
    output logic [bnc_pkg::POINTS_W-1:0] error_points,
    output logic [bnc_pkg::TOTAL_W-1:0]  total_error_points,
    output logic [bnc_pkg::SCORE_W-1:0]  completion_score,
    output logic [bnc_pkg::DEPTH_W-1:0]  open_depth
);
    import bnc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     walk_reg, walk_next;
    logic [CW-1:0]     depth_reg, depth_next;
    logic              corrupt_reg, corrupt_next;
    logic              overflow_reg, overflow_next;
    logic [POINTS_W-1:0] points_reg, points_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [SCORE_W-1:0]  score_reg, score_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [POINTS_W-1:0] out_points_reg, out_points_next;
    logic [TOTAL_W-1:0]  out_total_reg, out_total_next;
    logic [SCORE_W-1:0]  out_score_reg, out_score_next;
    logic [DEPTH_W-1:0]  out_depth_reg, out_depth_next;

    cell_op_t          stack_op;
    logic [CODE_W-1:0] push_code;
    logic [CODE_W-1:0] top_code;
    bracket_t          opener;
    bracket_t          closer;
    logic              accept;
    logic              out_free;
    logic [CW+DEPTH_W-1:0] depth_wide;

    bnc_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .op        (stack_op),
        .push_code (push_code),
        .top       (top_code)
    );

    assign opener   = opener_decode(ch);
    assign closer   = closer_decode(ch);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign depth_wide = {{DEPTH_W{1'b0}}, depth_reg};

    // line processing, end-of-line walk and output register
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        depth_next      = depth_reg;
        corrupt_next    = corrupt_reg;
        overflow_next   = overflow_reg;
        points_next     = points_reg;
        total_next      = total_reg;
        score_next      = score_reg;
        stack_op        = CELL_HOLD;
        push_code       = opener.kind;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_points_next = out_points_reg;
        out_total_next  = out_total_reg;
        out_score_next  = out_score_reg;
        out_depth_next  = out_depth_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // bytes after the first error of a line are ignored
                    if (!corrupt_reg && !overflow_reg)
                    begin
                        if (opener.hit)
                        begin
                            if (count_reg != FULL)
                            begin
                                stack_op   = CELL_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        else
                        begin
                            if (count_reg != '0)
                            begin
                                stack_op   = CELL_POP;
                                count_next = count_reg - 1'b1;
                            end
                            if (count_reg == '0 || !closer.hit || top_code != closer.kind)
                            begin
                                corrupt_next = 1'b1;
                                points_next  = closer_points(ch);
                                total_next   = total_reg + TOTAL_W'(closer_points(ch));
                            end
                        end
                    end
                    if (last)
                    begin
                        state_next = ST_WALK;
                        depth_next = count_next;
                        walk_next  = (corrupt_next || overflow_next) ? '0 : count_next;
                        score_next = '0;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_reg != '0)
                begin
                    // one base-5 digit per cycle from the top cell
                    stack_op   = CELL_POP;
                    walk_next  = walk_reg - 1'b1;
                    score_next = (score_reg << 2) + score_reg
                               + SCORE_W'({1'b0, top_code} + 3'd1);
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = corrupt_reg  ? STATUS_CORRUPT  :
                                      overflow_reg ? STATUS_OVERFLOW : STATUS_CLEAN;
                    out_points_next = corrupt_reg ? points_reg : PTS_NONE;
                    out_total_next  = total_reg;
                    out_score_next  = score_reg;
                    out_depth_next  = depth_wide[DEPTH_W-1:0];
                    count_next      = '0;
                    corrupt_next    = 1'b0;
                    overflow_next   = 1'b0;
                    points_next     = PTS_NONE;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            walk_reg      <= '0;
            corrupt_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            points_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            corrupt_reg   <= corrupt_next;
            overflow_reg  <= overflow_next;
            points_reg    <= points_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        depth_reg      <= depth_next;
        score_reg      <= score_next;
        out_status_reg <= out_status_next;
        out_points_reg <= out_points_next;
        out_total_reg  <= out_total_next;
        out_score_reg  <= out_score_next;
        out_depth_reg  <= out_depth_next;
    end

    assign out_valid          = out_valid_reg;
    assign line_status        = out_status_reg;
    assign error_points       = out_points_reg;
    assign total_error_points = out_total_reg;
    assign completion_score   = out_score_reg;
    assign open_depth         = out_depth_reg;

endmodule

/* hdl/bnc_cell.sv */
// bnc_cell: one stack cell holding a bracket kind code
// depends on: bnc_pkg

module bnc_cell (
    input  logic                      clk,
    input  bnc_pkg::cell_op_t         op,
    input  logic [bnc_pkg::CODE_W-1:0] from_above,
    input  logic [bnc_pkg::CODE_W-1:0] from_below,
    output logic [bnc_pkg::CODE_W-1:0] code
);
    import bnc_pkg::*;

    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;

    // push takes the neighbor above, pop takes the neighbor below
    always_comb
    begin
        case (op)
            CELL_PUSH: code_next = from_above;
            CELL_POP:  code_next = from_below;
            default:   code_next = code_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

/* hdl/bnc_stack.sv */
// bnc_stack: shift stack built as a chain of bnc_cell, top at cell 0
// depends on: bnc_pkg, bnc_cell

module bnc_stack #(
    parameter int DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
    input  logic                       clk,
    input  bnc_pkg::cell_op_t          op,
    input  logic [bnc_pkg::CODE_W-1:0] push_code,
    output logic [bnc_pkg::CODE_W-1:0] top
);
    import bnc_pkg::*;

    logic [CODE_W-1:0] codes [DEPTH];
    logic [CODE_W-1:0] above [DEPTH];
    logic [CODE_W-1:0] below [DEPTH];

    // every cell moves with the same op, data passes to the neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign above[i] = push_code;
        end
        else
        begin : g_mid_a
            assign above[i] = codes[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign below[i] = '0;
        end
        else
        begin : g_mid_b
            assign below[i] = codes[i+1];
        end

        bnc_cell u_cell (
            .clk        (clk),
            .op         (op),
            .from_above (above[i]),
            .from_below (below[i]),
            .code       (codes[i])
        );
    end

    assign top = codes[0];

endmodule

/* hdl/bnc_checker.sv */
// bnc_checker: port-level assertions for bracket_nesting_checker, with its bind
// depends on: bnc_pkg, bracket_nesting_checker

module bnc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         last,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bnc_pkg::STATUS_W-1:0] line_status,
    input logic [bnc_pkg::POINTS_W-1:0] error_points,
    input logic [bnc_pkg::TOTAL_W-1:0]  total_error_points,
    input logic [bnc_pkg::SCORE_W-1:0]  completion_score
);
    import bnc_pkg::*;

    // a waiting result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_error_points)
            && $stable(completion_score) && $stable(line_status))
        else $error("result word changed while stalled");

    // the end-of-line walk stalls the input
    a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input taken right after a line end");

    // a failed line has no completion score
    a_fail_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_status != STATUS_CLEAN |-> completion_score == '0)
        else $error("completion score on a failed line");

    // only a corrupted line carries error points
    a_points: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_status != STATUS_CORRUPT |-> error_points == PTS_NONE)
        else $error("error points on a line that is not corrupted");

    // status is one of the three line outcomes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_status == STATUS_CLEAN || line_status == STATUS_CORRUPT
            || line_status == STATUS_OVERFLOW)
        else $error("bad line status");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .last               (last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .line_status        (line_status),
    .error_points       (error_points),
    .total_error_points (total_error_points),
    .completion_score   (completion_score)
);
